// ===== rtl/aeq_pkg.sv =====
// aeq_pkg: shared constants and helper functions for the angle event queue.
// Used by aeq_cell and angle_event_queue; depends on nothing.
package aeq_pkg;

  localparam int ANGLE_W = 17;
  localparam int ACT_W   = 16;
  localparam int TIME_W  = 32;
  localparam int CMD_W   = 2;
  localparam int KIND_W  = 2;

  localparam logic [CMD_W-1:0] CMD_QUEUE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SCHED = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd2;
  localparam logic [CMD_W-1:0] CMD_TOOTH = 2'd3;

  localparam logic [KIND_W-1:0] KIND_FIRE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUEUED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DROP   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DONE   = 2'd3;

  localparam logic [ANGLE_W-1:0] CYCLE_RESET = 17'd72000;

  function automatic logic in_window(input logic [ANGLE_W-1:0] a,
                                     input logic [ANGLE_W-1:0] cur,
                                     input logic [ANGLE_W-1:0] nxt);
    logic after_cur;
    logic before_nxt;
    after_cur  = (a >= cur);
    before_nxt = (a < nxt);
    if (nxt > cur) begin
      return after_cur && before_nxt;
    end
    return after_cur || before_nxt;
  endfunction

  function automatic logic [ANGLE_W-1:0] from_now(input logic [ANGLE_W-1:0] a,
                                                  input logic [ANGLE_W-1:0] cur,
                                                  input logic [ANGLE_W-1:0] cyc);
    logic [ANGLE_W:0] sum;
    sum = {1'b0, a} + {1'b0, cyc} - {1'b0, cur};
    if (a < cur) begin
      return sum[ANGLE_W-1:0];
    end
    return a - cur;
  endfunction

endpackage

// ===== rtl/aeq_cell.sv =====
// aeq_cell: one list slot holding an event id, angle and action.
// Takes its upper neighbor on a shift or the broadcast word when addressed; uses aeq_pkg.
module aeq_cell import aeq_pkg::*; #(
  parameter int IDX   = 0,
  parameter int IDW   = 8,
  parameter int IDX_W = 5
) (
  input  logic               clk,
  input  logic               shift_en,
  input  logic               wr_en,
  input  logic [IDX_W-1:0]   wr_pos,
  input  logic [IDW-1:0]     wr_id,
  input  logic [ANGLE_W-1:0] wr_angle,
  input  logic [ACT_W-1:0]   wr_action,
  input  logic [IDW-1:0]     nb_id,
  input  logic [ANGLE_W-1:0] nb_angle,
  input  logic [ACT_W-1:0]   nb_action,
  output logic [IDW-1:0]     q_id,
  output logic [ANGLE_W-1:0] q_angle,
  output logic [ACT_W-1:0]   q_action
);

  logic [IDW-1:0]     id_r;
  logic [ANGLE_W-1:0] angle_r;
  logic [ACT_W-1:0]   action_r;

  always_ff @(posedge clk) begin
    if (wr_en && (wr_pos == IDX_W'(IDX))) begin
      id_r     <= wr_id;
      angle_r  <= wr_angle;
      action_r <= wr_action;
    end else if (shift_en) begin
      id_r     <= nb_id;
      angle_r  <= nb_angle;
      action_r <= nb_action;
    end
  end

  assign q_id     = id_r;
  assign q_angle  = angle_r;
  assign q_action = action_r;

endmodule

// ===== rtl/angle_event_queue.sv =====
// angle_event_queue: ordered list of pending crank-angle events in a row of cells.
// Each request scans the list (a stopped tooth skips the scan); the final result is
// registered once the output is free. One request at a time: in_stall holds the next.
// Each scan step moves the row down one cell and rewrites a kept head at the tail.
// A tooth emits a result per fired event, last flagged (DONE if none); others emit one.
// Synchronous active-low reset empties the list and sets engine_cycle to 72000.
module angle_event_queue import aeq_pkg::*; #(
  parameter int MAX_EVENTS = 32,
  parameter int ID_BITS    = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [ANGLE_W-1:0] cfg_engine_cycle,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CMD_W-1:0]   in_command,
  input  logic [ID_BITS-1:0] in_event_id,
  input  logic [ANGLE_W-1:0] in_angle,
  input  logic [ACT_W-1:0]   in_action,
  input  logic [ANGLE_W-1:0] in_current_phase,
  input  logic [ANGLE_W-1:0] in_next_phase,
  input  logic               in_engine_stopped,
  input  logic [TIME_W-1:0]  in_edge_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [KIND_W-1:0]  out_kind,
  output logic [ID_BITS-1:0] out_fired_event,
  output logic [ACT_W-1:0]   out_fired_action,
  output logic [ANGLE_W-1:0] out_angle_from_now,
  output logic [TIME_W-1:0]  out_base_time,
  output logic               out_last
);

  localparam int CNT_W = $clog2(MAX_EVENTS + 1);
  localparam int IDX_W = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} state_t;

  state_t             state_r;
  logic [ANGLE_W-1:0] cycle_r;
  logic [CMD_W-1:0]   cmd_r;
  logic [ID_BITS-1:0] id_r;
  logic [ANGLE_W-1:0] ang_r;
  logic [ACT_W-1:0]   act_r;
  logic [ANGLE_W-1:0] cur_r;
  logic [ANGLE_W-1:0] nxt_r;
  logic               stop_r;
  logic [TIME_W-1:0]  et_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   step_r;
  logic [CNT_W-1:0]   kept_r;
  logic               found_r;
  logic               pend_valid_r;
  logic [ID_BITS-1:0] pend_id_r;
  logic [ACT_W-1:0]   pend_act_r;
  logic [ANGLE_W-1:0] pend_afn_r;
  logic               out_valid_r;
  logic [KIND_W-1:0]  out_kind_r;
  logic [ID_BITS-1:0] out_id_r;
  logic [ACT_W-1:0]   out_act_r;
  logic [ANGLE_W-1:0] out_afn_r;
  logic [TIME_W-1:0]  out_bt_r;
  logic               out_last_r;

  logic [ID_BITS-1:0] c_id     [MAX_EVENTS];
  logic [ANGLE_W-1:0] c_angle  [MAX_EVENTS];
  logic [ACT_W-1:0]   c_action [MAX_EVENTS];

  logic               out_free;
  logic               out_load;
  logic               sched_win;
  logic               is_enq;
  logic               scan_done;
  logic               match;
  logic               due;
  logic               keep;
  logic               step_ok;
  logic               shift_en;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_pos;
  logic [CNT_W-1:0]   scan_pos;
  logic [ANGLE_W-1:0] wr_angle;
  logic [ACT_W-1:0]   wr_action;
  logic [ID_BITS-1:0] wr_id;
  logic               do_append;

  assign out_free  = !out_valid_r || !out_stall;
  assign sched_win = in_window(ang_r, cur_r, nxt_r);
  assign is_enq    = (cmd_r == CMD_QUEUE) || ((cmd_r == CMD_SCHED) && !sched_win);
  assign scan_done = (step_r == cnt_r) || ((cmd_r == CMD_TOOTH) && stop_r);
  assign match     = !found_r && (c_id[0] == id_r);
  assign due       = in_window(c_angle[0], cur_r, nxt_r);
  assign do_append = (state_r == S_FIN) && out_free && is_enq && !found_r &&
                     (cnt_r < CNT_W'(MAX_EVENTS));

  always_comb begin
    keep = 1'b1;
    case (cmd_r)
      CMD_CANCEL: keep = !match;
      CMD_TOOTH:  keep = !due;
      default:    keep = 1'b1;
    endcase
  end

  assign step_ok  = !((cmd_r == CMD_TOOTH) && due && pend_valid_r && !out_free);
  assign shift_en = (state_r == S_SCAN) && !scan_done && step_ok;
  assign scan_pos = cnt_r - step_r - CNT_W'(1) + kept_r;
  assign out_load = (shift_en && (cmd_r == CMD_TOOTH) && due && pend_valid_r) ||
                    ((state_r == S_FIN) && out_free);

  always_comb begin
    wr_en     = 1'b0;
    wr_pos    = scan_pos[IDX_W-1:0];
    wr_id     = c_id[0];
    wr_angle  = c_angle[0];
    wr_action = c_action[0];
    if (shift_en) begin
      wr_en = keep;
      if ((cmd_r != CMD_CANCEL) && (cmd_r != CMD_TOOTH) && match) begin
        wr_angle = ang_r;
        if (is_enq) begin
          wr_action = act_r;
        end
      end
    end else if (do_append) begin
      wr_en     = 1'b1;
      wr_pos    = cnt_r[IDX_W-1:0];
      wr_id     = id_r;
      wr_angle  = ang_r;
      wr_action = act_r;
    end
  end

  for (genvar gi = 0; gi < MAX_EVENTS; gi++) begin : g_cell
    logic [ID_BITS-1:0] nb_id;
    logic [ANGLE_W-1:0] nb_angle;
    logic [ACT_W-1:0]   nb_action;
    if (gi < MAX_EVENTS - 1) begin : g_mid
      assign nb_id     = c_id[gi+1];
      assign nb_angle  = c_angle[gi+1];
      assign nb_action = c_action[gi+1];
    end else begin : g_end
      assign nb_id     = '0;
      assign nb_angle  = '0;
      assign nb_action = '0;
    end
    aeq_cell #(.IDX(gi), .IDW(ID_BITS), .IDX_W(IDX_W)) u_cell (
      .clk       (clk),
      .shift_en  (shift_en),
      .wr_en     (wr_en),
      .wr_pos    (wr_pos),
      .wr_id     (wr_id),
      .wr_angle  (wr_angle),
      .wr_action (wr_action),
      .nb_id     (nb_id),
      .nb_angle  (nb_angle),
      .nb_action (nb_action),
      .q_id      (c_id[gi]),
      .q_angle   (c_angle[gi]),
      .q_action  (c_action[gi])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cycle_r      <= CYCLE_RESET;
      cnt_r        <= '0;
      step_r       <= '0;
      kept_r       <= '0;
      found_r      <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cycle_r <= cfg_engine_cycle;
      end
      if (out_valid_r && !out_stall && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r   <= in_command;
            id_r    <= in_event_id;
            ang_r   <= in_angle;
            act_r   <= in_action;
            cur_r   <= in_current_phase;
            nxt_r   <= in_next_phase;
            stop_r  <= in_engine_stopped;
            et_r    <= in_edge_time;
            step_r  <= '0;
            kept_r  <= '0;
            found_r <= 1'b0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            state_r <= S_FIN;
          end else if (step_ok) begin
            step_r <= step_r + CNT_W'(1);
            kept_r <= kept_r + CNT_W'(keep);
            if (match) begin
              found_r <= 1'b1;
            end
            if ((cmd_r == CMD_TOOTH) && due) begin
              if (pend_valid_r) begin
                out_valid_r <= 1'b1;
                out_kind_r  <= KIND_FIRE;
                out_id_r    <= pend_id_r;
                out_act_r   <= pend_act_r;
                out_afn_r   <= pend_afn_r;
                out_bt_r    <= et_r;
                out_last_r  <= 1'b0;
              end
              pend_valid_r <= 1'b1;
              pend_id_r    <= c_id[0];
              pend_act_r   <= c_action[0];
              pend_afn_r   <= from_now(c_angle[0], cur_r, cycle_r);
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_last_r   <= 1'b1;
            out_id_r     <= id_r;
            out_act_r    <= act_r;
            out_afn_r    <= '0;
            out_bt_r     <= '0;
            pend_valid_r <= 1'b0;
            state_r      <= S_IDLE;
            if (is_enq) begin
              if (found_r) begin
                out_kind_r <= KIND_QUEUED;
              end else if (do_append) begin
                out_kind_r <= KIND_QUEUED;
                cnt_r      <= cnt_r + CNT_W'(1);
              end else begin
                out_kind_r <= KIND_DROP;
              end
            end else if (cmd_r == CMD_SCHED) begin
              out_kind_r <= KIND_FIRE;
              out_afn_r  <= from_now(ang_r, cur_r, cycle_r);
              out_bt_r   <= et_r;
            end else if (cmd_r == CMD_CANCEL) begin
              out_kind_r <= KIND_DONE;
              out_act_r  <= '0;
              cnt_r      <= kept_r;
            end else begin
              if (!stop_r) begin
                cnt_r <= kept_r;
              end
              if (pend_valid_r) begin
                out_kind_r <= KIND_FIRE;
                out_id_r   <= pend_id_r;
                out_act_r  <= pend_act_r;
                out_afn_r  <= pend_afn_r;
                out_bt_r   <= et_r;
              end else begin
                out_kind_r <= KIND_DONE;
                out_id_r   <= '0;
                out_act_r  <= '0;
              end
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign cfg_ready          = (state_r == S_IDLE);
  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_fired_event    = out_id_r;
  assign out_fired_action   = out_act_r;
  assign out_angle_from_now = out_afn_r;
  assign out_base_time      = out_bt_r;
  assign out_last           = out_last_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_EVENTS)) else $error("entry count above capacity");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (step_r <= cnt_r)) else $error("scan step past count");

  a_pend_tooth: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (cmd_r == CMD_TOOTH)) else $error("pending fire outside tooth");

  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_FIN) && out_free) |=> (out_valid_r && out_last_r && (state_r == S_IDLE)))
    else $error("final result not issued");

endmodule
